>>> hw/rtl/m2r_pkg.sv
// Shared types and constants for the mono to RGB444 LCD byte stream block.
// No dependencies; imported by m2r_burst_gen and mono_to_rgb444_lcd_stream.
package m2r_pkg;

  // Controller command opcodes.
  localparam logic [7:0] OpColumnSet = 8'h2A;
  localparam logic [7:0] OpRowSet    = 8'h2B;
  localparam logic [7:0] OpMemWrite  = 8'h2C;

  // Pixel nibbles: a set bit draws black, a clear bit white.
  localparam logic [3:0] NibSet   = 4'h0;
  localparam logic [3:0] NibClear = 4'hF;

  // Longest burst of bytes caused by one request, and header length.
  localparam int unsigned BurstLen  = 12;
  localparam logic [3:0]  HeaderLen = 4'd11;
  localparam int unsigned CountW    = 33;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegColStart = 3'd0;
  localparam logic [2:0] RegRowStart = 3'd1;
  localparam logic [2:0] RegColEnd   = 3'd2;
  localparam logic [2:0] RegRowEnd   = 3'd3;

  // Request action codes.
  localparam logic ActStart = 1'b0;
  localparam logic ActFrame = 1'b1;

  typedef struct packed {
    logic [15:0] col_start;
    logic [15:0] row_start;
    logic [15:0] col_end;
    logic [15:0] row_end;
  } cfg_t;

  // One request's worth of output bytes, byte 0 sent first.
  typedef struct packed {
    logic [BurstLen-1:0][7:0] bytes;
    logic [BurstLen-1:0]      is_data;
    logic [3:0]               count;
    logic                     last;
  } burst_t;

endpackage

>>> hw/rtl/mono_to_rgb444_lcd_stream.sv
// Mono frame to RGB444 LCD controller byte stream, top level.
// The first byte of a request's burst is registered and valid in the cycle after accept.
// Throughput: a request holds the output shifter for its byte count (11 for a
// start, up to 12 for a frame byte), one byte per cycle while the output is not
// stalled; the next request is taken as the last byte leaves.
// Reset: registers to 0, 0, 239, 239, no active window, output empty.
module mono_to_rgb444_lcd_stream (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // Input request channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [7:0]  mono_bits_i,
  // Output byte channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        is_data_o,
  output logic        last_o
);
  import m2r_pkg::*;

  cfg_t                     cfg_q;
  logic [CountW-1:0]        pl_q;
  logic [CountW-1:0]        pl_d;
  logic                     active_q;
  logic                     active_d;
  logic [BurstLen-1:0][7:0] byte_q;
  logic [BurstLen-1:0]      data_q;
  logic [3:0]               rem_q;
  logic                     last_q;
  burst_t                   burst;
  logic                     in_acc;
  logic                     out_acc;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.col_start <= 16'd0;
      cfg_q.row_start <= 16'd0;
      cfg_q.col_end   <= 16'd239;
      cfg_q.row_end   <= 16'd239;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegColStart: cfg_q.col_start <= cfg_wdata_i;
        RegRowStart: cfg_q.row_start <= cfg_wdata_i;
        RegColEnd:   cfg_q.col_end   <= cfg_wdata_i;
        RegRowEnd:   cfg_q.row_end   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  m2r_burst_gen u_gen (
    .cfg_i         (cfg_q),
    .action_i      (action_i),
    .mono_bits_i   (mono_bits_i),
    .pixels_left_i (pl_q),
    .active_i      (active_q),
    .burst_o       (burst),
    .pixels_left_o (pl_d),
    .active_o      (active_d)
  );

  // Handshakes: a new request loads as the final queued byte is taken.
  assign out_valid_o = (rem_q != 4'd0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign in_stall_o  = out_valid_o && !(out_acc && (rem_q == 4'd1));
  assign in_acc      = in_valid_i && !in_stall_o;

  // Window state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pl_q     <= '0;
      active_q <= 1'b0;
    end else if (in_acc) begin
      pl_q     <= pl_d;
      active_q <= active_d;
    end
  end

  // Output shifter control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= 4'd0;
      last_q <= 1'b0;
    end else if (in_acc) begin
      rem_q  <= burst.count;
      last_q <= burst.last;
    end else if (out_acc) begin
      rem_q  <= rem_q - 4'd1;
    end
  end

  // Output shifter payload; byte 0 is on the port.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= burst.bytes;
      data_q <= burst.is_data;
    end else if (out_acc) begin
      byte_q <= byte_q >> 8;
      data_q <= data_q >> 1;
    end
  end

  assign out_byte_o = byte_q[0];
  assign is_data_o  = data_q[0];
  assign last_o     = last_q && (rem_q == 4'd1);

  // The window is active exactly while pixels remain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q == (pl_q != '0))
    else $error("window active flag disagrees with pixel count");

  // A burst never holds more bytes than the shifter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 4'(BurstLen))
    else $error("output burst count out of range");

  // The final byte of a transfer is only shown once the window has closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> !active_q)
    else $error("last byte shown while window still active");

  // A stalled byte stays queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled output byte dropped");

endmodule

>>> hw/rtl/m2r_burst_gen.sv
// Builds the full byte burst for one request: window header or packed pixels.
// Depends on m2r_pkg for the config and burst types.
module m2r_burst_gen (
  input  m2r_pkg::cfg_t                   cfg_i,
  input  logic                            action_i,
  input  logic [7:0]                      mono_bits_i,
  input  logic [m2r_pkg::CountW-1:0]      pixels_left_i,
  input  logic                            active_i,
  output m2r_pkg::burst_t                 burst_o,
  output logic [m2r_pkg::CountW-1:0]      pixels_left_o,
  output logic                            active_o
);
  import m2r_pkg::*;

  logic [16:0]       span_col;
  logic [16:0]       span_row;
  logic [CountW-1:0] area;
  logic              area_zero;
  logic [3:0]        npix;
  logic [CountW-1:0] left_next;
  logic [3:0]        frame_count;
  burst_t            hdr;
  burst_t            frm;

  // Window spans; an end below its start gives an empty span.
  always_comb begin
    span_col = (cfg_i.col_end < cfg_i.col_start) ? 17'd0 :
               ({1'b0, cfg_i.col_end} - {1'b0, cfg_i.col_start} + 17'd1);
    span_row = (cfg_i.row_end < cfg_i.row_start) ? 17'd0 :
               ({1'b0, cfg_i.row_end} - {1'b0, cfg_i.row_start} + 17'd1);
    // The largest area, 65536 * 65536, still fits the pixel count.
    area      = {16'd0, span_col} * {16'd0, span_row};
    area_zero = (span_col == 17'd0) || (span_row == 17'd0);
  end

  // Window header: column-set, x pair, row-set, y pair, memory-write.
  always_comb begin
    hdr.bytes          = '0;
    hdr.bytes[0]       = OpColumnSet;
    hdr.bytes[1]       = cfg_i.col_start[15:8];
    hdr.bytes[2]       = cfg_i.col_start[7:0];
    hdr.bytes[3]       = cfg_i.col_end[15:8];
    hdr.bytes[4]       = cfg_i.col_end[7:0];
    hdr.bytes[5]       = OpRowSet;
    hdr.bytes[6]       = cfg_i.row_start[15:8];
    hdr.bytes[7]       = cfg_i.row_start[7:0];
    hdr.bytes[8]       = cfg_i.row_end[15:8];
    hdr.bytes[9]       = cfg_i.row_end[7:0];
    hdr.bytes[10]      = OpMemWrite;
    hdr.is_data        = 12'b0011_1101_1110;
    hdr.count          = HeaderLen;
    hdr.last           = area_zero;
  end

  // Pixel count for this frame byte, clipped to what the window still needs.
  always_comb begin
    npix        = (pixels_left_i < CountW'(8)) ? {1'b0, pixels_left_i[2:0]} : 4'd8;
    left_next   = pixels_left_i - CountW'(npix);
    frame_count = {npix[3:1], 1'b0} + {1'b0, npix[3:1]} + {2'b00, npix[0], 1'b0};
  end

  // Pack pixel pairs into three bytes; a lone final pixel pads with white.
  always_comb begin
    logic [3:0] na;
    logic [3:0] nb;
    frm.bytes   = '0;
    frm.is_data = '1;
    frm.count   = frame_count;
    frm.last    = (left_next == '0);
    for (int j = 0; j < 4; j++) begin
      na = mono_bits_i[2*j]     ? NibSet : NibClear;
      nb = mono_bits_i[2*j + 1] ? NibSet : NibClear;
      frm.bytes[3*j]     = {na, na};
      frm.bytes[3*j + 1] = {na, ((4'(2*j + 1) < npix) ? nb : NibClear)};
      frm.bytes[3*j + 2] = {nb, nb};
    end
  end

  // Select the burst and the next window state.
  always_comb begin
    if (action_i == ActStart) begin
      burst_o       = hdr;
      pixels_left_o = area;
      active_o      = !area_zero;
    end else if (!active_i || (pixels_left_i == '0)) begin
      burst_o       = frm;
      burst_o.count = 4'd0;
      pixels_left_o = pixels_left_i;
      active_o      = 1'b0;
    end else begin
      burst_o       = frm;
      pixels_left_o = left_next;
      active_o      = (left_next != '0);
    end
  end

endmodule

>>> dv/mono_to_rgb444_lcd_stream_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for mono_to_rgb444_lcd_stream: window headers and RGB444 pixel bytes.
// Depends on m2r_pkg and the block itself; a byte predictor class checks every output byte.

module mono_to_rgb444_lcd_stream_tb;
  import m2r_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       last;
  } lcd_byte_t;

  // Predicts the byte stream for each accepted request and checks the bytes that come out.
  class lcd_byte_predictor;
    logic [15:0] col_start, row_start, col_end, row_end;
    logic [32:0] pixels_left;
    bit          window_active;
    lcd_byte_t   expected_bytes[$];
    int          mismatches;

    function new();
      col_start     = 16'd0;
      row_start     = 16'd0;
      col_end       = 16'd239;
      row_end       = 16'd239;
      pixels_left   = '0;
      window_active = 1'b0;
      mismatches    = 0;
    endfunction

    // Indexes past the register list leave everything unchanged.
    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        RegColStart: col_start = val;
        RegRowStart: row_start = val;
        RegColEnd:   col_end   = val;
        RegRowEnd:   row_end   = val;
        default: ;
      endcase
    endfunction

    function logic [16:0] extent(logic [15:0] lo, logic [15:0] hi);
      if (hi < lo) return 17'd0;
      return {1'b0, hi} - {1'b0, lo} + 17'd1;
    endfunction

    function void push(logic [7:0] value, logic is_data, logic last);
      lcd_byte_t b;
      b.value   = value;
      b.is_data = is_data;
      b.last    = last;
      expected_bytes.push_back(b);
    endfunction

    function void note_request(logic act, logic [7:0] bits);
      logic [33:0] area;
      logic [3:0]  n;
      logic [3:0]  na, nb;
      // A start request sends the window header and latches the pixel count.
      if (act == ActStart) begin
        area = extent(col_start, col_end) * extent(row_start, row_end);
        push(OpColumnSet, 1'b0, 1'b0);
        push(col_start[15:8], 1'b1, 1'b0);
        push(col_start[7:0], 1'b1, 1'b0);
        push(col_end[15:8], 1'b1, 1'b0);
        push(col_end[7:0], 1'b1, 1'b0);
        push(OpRowSet, 1'b0, 1'b0);
        push(row_start[15:8], 1'b1, 1'b0);
        push(row_start[7:0], 1'b1, 1'b0);
        push(row_end[15:8], 1'b1, 1'b0);
        push(row_end[7:0], 1'b1, 1'b0);
        push(OpMemWrite, 1'b0, area[32:0] == '0);
        pixels_left   = area[32:0];
        window_active = (area[32:0] != '0);
        return;
      end
      // Frame bytes outside an active window give nothing.
      if (!window_active || pixels_left == '0) begin
        window_active = 1'b0;
        return;
      end
      n = (pixels_left < 33'd8) ? pixels_left[3:0] : 4'd8;
      pixels_left = pixels_left - n;
      // Two pixels fill three bytes; a lone final pixel is padded with a clear nibble.
      for (int i = 0; i < n; i += 2) begin
        na = bits[i] ? NibSet : NibClear;
        if (i + 1 < n) begin
          nb = bits[i+1] ? NibSet : NibClear;
          push({na, na}, 1'b1, 1'b0);
          push({na, nb}, 1'b1, 1'b0);
          push({nb, nb}, 1'b1, (i + 2 == n) && (pixels_left == '0));
        end else begin
          push({na, na}, 1'b1, 1'b0);
          push({na, NibClear}, 1'b1, pixels_left == '0);
        end
      end
      if (pixels_left == '0) window_active = 1'b0;
    endfunction

    function void check_byte(logic [7:0] value, logic is_data, logic last);
      lcd_byte_t exp_b;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual %h is_data %b last %b",
                 $time, value, is_data, last);
        mismatches++;
        return;
      end
      exp_b = expected_bytes.pop_front();
      if (exp_b.value !== value) begin
        $display("%0t: out_byte expected %h actual %h", $time, exp_b.value, value);
        mismatches++;
      end
      if (exp_b.is_data !== is_data) begin
        $display("%0t: is_data expected %b actual %b", $time, exp_b.is_data, is_data);
        mismatches++;
      end
      if (exp_b.last !== last) begin
        $display("%0t: last expected %b actual %b", $time, exp_b.last, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 400;
  localparam int SettleCycles = 20;
  localparam int TargetItems = 280;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = RegColStart;
  logic [15:0] cfg_wdata_i = 16'd0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        action_i    = ActStart;
  logic [7:0]  mono_bits_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        is_data_o;
  logic        last_o;

  lcd_byte_predictor sb;
  int  cycles     = 0;
  int  items_sent = 0;
  int  hold_left  = 0;
  bit  hold_go    = 1'b0;
  bit  hold_done  = 1'b0;
  bit  calm       = 1'b0;

  mono_to_rgb444_lcd_stream u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .mono_bits_i (mono_bits_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .is_data_o   (is_data_o),
    .last_o      (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Output side: check accepted bytes, then choose the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_byte(out_byte_o, is_data_o, last_o);
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HoldCycles;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 31);
    end
  end

  // Offer one request, with random idle cycles ahead of it, and wait until it is taken.
  task automatic send_request(input logic act, input logic [7:0] bits);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    mono_bits_i <= bits;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(act, bits);
    items_sent++;
  endtask

  // Let every expected byte drain, then let the block settle while idle.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // Program a new window while the block is idle.
  task automatic set_window(input logic [15:0] cs, input logic [15:0] rs,
                            input logic [15:0] ce, input logic [15:0] re);
    quiesce();
    write_reg(RegColStart, cs);
    write_reg(RegRowStart, rs);
    write_reg(RegColEnd, ce);
    write_reg(RegRowEnd, re);
    if ($urandom_range(3) == 0) write_reg(3'($urandom_range(4, 7)), 16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_frames(input int count);
    for (int i = 0; i < count; i++) send_request(ActFrame, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int kind, w, h, area, phase;
    logic [15:0] cs, rs, ce, re;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: frame byte with no window, then the reset window with extreme pixel patterns.
    send_request(ActFrame, 8'hFF);
    send_request(ActStart, 8'h00);
    send_request(ActFrame, 8'h00);
    send_request(ActFrame, 8'hFF);
    send_request(ActFrame, 8'h01);
    send_request(ActFrame, 8'h80);
    // Full 65536 x 65536 window, then a restart while it is active.
    set_window(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_request(ActStart, 8'h00);
    send_request(ActFrame, 8'hAA);
    send_request(ActStart, 8'hFF);
    // Empty window: column end below column start; the frame byte after it gives nothing.
    set_window(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    @(posedge clk_i);
    write_reg(3'd5, 16'hA5A5);
    write_reg(3'd7, 16'h5A5A);
    cfg_we_i <= 1'b0;
    send_request(ActStart, 8'h00);
    send_request(ActFrame, 8'h3C);
    // Odd area of three pixels: surplus bits dropped and a padded final byte.
    set_window(16'h1234, 16'hFEDC, 16'h1236, 16'hFEDC);
    send_request(ActStart, 8'h00);
    send_request(ActFrame, 8'h55);
    send_request(ActFrame, 8'hFF);
    // Area of exactly eight pixels.
    set_window(16'h00FF, 16'hFF00, 16'h0100, 16'hFF03);
    send_request(ActStart, 8'h00);
    send_request(ActFrame, 8'h0F);
    send_request(ActFrame, 8'hF0);
    // Single pixel at the far corner.
    set_window(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(ActStart, 8'h00);
    send_request(ActFrame, 8'h01);
    // Empty window: row end below row start.
    set_window(16'h0000, 16'h0005, 16'h0000, 16'h0004);
    send_request(ActStart, 8'h00);

    // Random windows, mostly small and well formed.
    phase = 0;
    while (items_sent < TargetItems) begin
      kind = $urandom_range(0, 19);
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      if (phase == 0) begin
        kind = 4;
        w = 8;
        h = 8;
      end
      calm = (phase >= 5 && phase < 10);
      if (kind == 0) begin
        cs = 16'($urandom_range(1, 65535));
        ce = 16'($urandom_range(0, cs - 1));
        rs = 16'($urandom);
        re = 16'($urandom);
        if ($urandom_range(1) == 1) begin
          cs = rs;
          ce = re;
          rs = 16'($urandom_range(1, 65535));
          re = 16'($urandom_range(0, rs - 1));
        end
        area = 0;
      end else if (kind == 1) begin
        cs = 16'($urandom_range(0, 255));
        rs = 16'($urandom_range(0, 255));
        ce = 16'($urandom_range(65000, 65535));
        re = 16'($urandom_range(65000, 65535));
        area = -1;
      end else begin
        cs = (kind == 2) ? 16'(65536 - w) : (kind == 3) ? 16'd0 : 16'($urandom_range(0, 65536 - w));
        rs = (kind == 3) ? 16'(65536 - h) : (kind == 2) ? 16'd0 : 16'($urandom_range(0, 65536 - h));
        ce = cs + 16'(w - 1);
        re = rs + 16'(h - 1);
        area = w * h;
      end
      set_window(cs, rs, ce, re);
      // The long receiver hold lands on the first random window, which has eight frame bytes.
      if (phase == 0) hold_go <= 1'b1;
      send_request(ActStart, 8'($urandom));
      if (area > 8 && $urandom_range(4) == 0) begin
        send_frames(1);
        send_request(ActStart, 8'($urandom));
      end
      if (area > 0) send_frames((area + 7) / 8);
      else if (area < 0) send_frames($urandom_range(1, 3));
      else send_frames($urandom_range(0, 1));
      if ($urandom_range(2) == 0) send_frames(1);
      phase++;
    end
    calm = 1'b0;

    // Drain and let the block settle before the verdict.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
